### src/gbc_pkg.sv
package gbc_pkg;

  localparam int unsigned LIMIT_W    = 23;
  localparam int unsigned RATE_W     = 14;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 23;

  localparam logic [RATE_W-1:0]  RATE_RST        = 14'd1000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST       = 16'd328;
  localparam logic [LIMIT_W-1:0] GYRO_LIMIT_RST  = 23'd13107;
  localparam logic [LIMIT_W-1:0] ACCEL_LIMIT_RST = 23'd3277;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_UPDATE = 3'd2,
    PH_APPLY  = 3'd3,
    PH_SAVE   = 3'd4
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_RATE    = 2'd0,
    REG_BIAS_ALPHA  = 2'd1,
    REG_GYRO_LIMIT  = 2'd2,
    REG_ACCEL_LIMIT = 2'd3
  } cfg_reg_e;

endpackage

### src/gbc_if.sv
interface gbc_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic                           start_request;
  logic signed [SAMPLE_WIDTH-1:0] gyro_x;
  logic signed [SAMPLE_WIDTH-1:0] gyro_y;
  logic signed [SAMPLE_WIDTH-1:0] gyro_z;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;

  modport source (
    output valid, start_request, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
    input  ready
  );
  modport sink (
    input  valid, start_request, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
    output ready
  );
endinterface

interface gbc_out_if #(
  parameter int unsigned SAMPLE_WIDTH = 24
);
  import gbc_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] rate_x;
  logic signed [SAMPLE_WIDTH-1:0] rate_y;
  logic signed [SAMPLE_WIDTH-1:0] rate_z;
  logic [PHASE_W-1:0]             phase_now;
  logic                           calibration_done;

  modport source (
    output valid, rate_x, rate_y, rate_z, phase_now, calibration_done,
    input  ready
  );
  modport sink (
    input  valid, rate_x, rate_y, rate_z, phase_now, calibration_done,
    output ready
  );
endinterface

interface gbc_cfg_if;
  import gbc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

### src/gbc_still_check.sv
module gbc_still_check #(
  parameter int unsigned VEC_W = 25
) (
  input  logic signed [VEC_W-1:0]            vec_x_i,
  input  logic signed [VEC_W-1:0]            vec_y_i,
  input  logic signed [VEC_W-1:0]            vec_z_i,
  input  logic [gbc_pkg::LIMIT_W-1:0]        limit_i,
  output logic                               still_o
);
  import gbc_pkg::*;

  localparam int unsigned CMP_W = (VEC_W > LIMIT_W) ? VEC_W : LIMIT_W;
  localparam int unsigned SQ_W  = 2 * LIMIT_W;
  localparam int unsigned SUM_W = SQ_W + 2;

  logic signed [VEC_W-1:0] comp  [3];
  logic [VEC_W-1:0]        mag   [3];
  logic [CMP_W-1:0]        mag_w [3];
  logic [LIMIT_W-1:0]      mag_n [3];
  logic [SQ_W-1:0]         sq    [3];
  logic [CMP_W-1:0]        lim_w;
  logic [SQ_W-1:0]         lim_sq;
  logic [SUM_W-1:0]        sum;
  logic                    over;

  always_comb begin
    comp[0] = vec_x_i;
    comp[1] = vec_y_i;
    comp[2] = vec_z_i;
    lim_w   = CMP_W'(limit_i);
    lim_sq  = limit_i * limit_i;
    over    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      // magnitude of the most negative value still fits unsigned
      mag[i]   = comp[i][VEC_W-1] ? VEC_W'(-comp[i]) : VEC_W'(comp[i]);
      mag_w[i] = CMP_W'(mag[i]);
      mag_n[i] = mag_w[i][LIMIT_W-1:0];
      sq[i]    = mag_n[i] * mag_n[i];
      over     = over | (mag_w[i] > lim_w);
    end
    sum     = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    still_o = !over && (sum < SUM_W'(lim_sq));
  end

endmodule

### src/gyro_bias_calibration.sv
// A word accepted into the input register moves to the output register once the output
//   can advance, then shows on out_o.
// Throughput: one word per cycle unless out_o stalls; the bias update (one multiply, add,
//   saturate) and both stillness sum-of-squares compares close the per-sample state loop.
// Reset: start phase, bias, previous accel and countdown cleared, registers at defaults.
module gyro_bias_calibration #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbc_in_if.sink     in_i,
  gbc_out_if.source  out_o,
  gbc_cfg_if.sink    cfg_i
);
  import gbc_pkg::*;

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned PROD_W = SW + ALPHA_W + 2;
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  // configuration
  logic [RATE_W-1:0]  rate_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [LIMIT_W-1:0] gyro_lim_q;
  logic [LIMIT_W-1:0] accel_lim_q;

  // input register
  logic                 in_valid_q;
  logic                 start_q;
  logic signed [SW-1:0] gyro_q  [3];
  logic signed [SW-1:0] accel_q [3];

  // calibration state
  phase_e               phase_q, phase_d, eff_phase;
  logic signed [SW-1:0] bias_q [3];
  logic signed [SW-1:0] bias_d [3];
  logic signed [SW-1:0] prev_q [3];
  logic signed [SW-1:0] prev_d [3];
  logic [COUNT_W-1:0]   cnt_q, cnt_d, cnt_dec;

  // output register
  logic                 out_valid_q;
  logic signed [SW-1:0] rate_out_q [3];
  logic signed [SW-1:0] rate_out_d [3];
  phase_e               phase_out_q;
  logic                 done_q, done_d;

  // datapath
  logic signed [SW:0]       bdiff    [3];
  logic signed [SW:0]       adiff    [3];
  logic signed [PROD_W-1:0] prod     [3];
  logic signed [PROD_W-1:0] bstep    [3];
  logic signed [PROD_W-1:0] bsum     [3];
  logic signed [SW-1:0]     bias_new [3];
  logic signed [SW-1:0]     rate_idl [3];
  logic                     accel_still, gyro_still, still;
  logic                     advance, fire;

  assign advance     = !out_valid_q || out_o.ready;
  assign fire        = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RATE_RST;
      alpha_q     <= ALPHA_RST;
      gyro_lim_q  <= GYRO_LIMIT_RST;
      accel_lim_q <= ACCEL_LIMIT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_CAL_RATE:    rate_q      <= cfg_i.data[RATE_W-1:0];
        REG_BIAS_ALPHA:  alpha_q     <= cfg_i.data[ALPHA_W-1:0];
        REG_GYRO_LIMIT:  gyro_lim_q  <= cfg_i.data[LIMIT_W-1:0];
        REG_ACCEL_LIMIT: accel_lim_q <= cfg_i.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      start_q    <= in_i.start_request;
      gyro_q[0]  <= in_i.gyro_x;
      gyro_q[1]  <= in_i.gyro_y;
      gyro_q[2]  <= in_i.gyro_z;
      accel_q[0] <= in_i.accel_x;
      accel_q[1] <= in_i.accel_y;
      accel_q[2] <= in_i.accel_z;
    end
  end

  assign eff_phase = start_q ? PH_START : phase_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bdiff[i] = {gyro_q[i][SW-1], gyro_q[i]} - {bias_q[i][SW-1], bias_q[i]};
      adiff[i] = {accel_q[i][SW-1], accel_q[i]} - {prev_q[i][SW-1], prev_q[i]};
      prod[i]  = bdiff[i] * $signed({1'b0, alpha_q});
      bstep[i] = prod[i] >>> ALPHA_W;
      bsum[i]  = bstep[i] + PROD_W'(bias_q[i]);
      // in range when the result sign bit and all bits above it agree
      if ((&bsum[i][PROD_W-1:SW-1]) || !(|bsum[i][PROD_W-1:SW-1])) begin
        bias_new[i] = bsum[i][SW-1:0];
      end else begin
        bias_new[i] = bsum[i][PROD_W-1] ? S_MIN : S_MAX;
      end
      if (bdiff[i][SW] == bdiff[i][SW-1]) begin
        rate_idl[i] = bdiff[i][SW-1:0];
      end else begin
        rate_idl[i] = bdiff[i][SW] ? S_MIN : S_MAX;
      end
    end
  end

  gbc_still_check #(
    .VEC_W (SW + 1)
  ) u_accel_still (
    .vec_x_i (adiff[0]),
    .vec_y_i (adiff[1]),
    .vec_z_i (adiff[2]),
    .limit_i (accel_lim_q),
    .still_o (accel_still)
  );

  gbc_still_check #(
    .VEC_W (SW)
  ) u_gyro_still (
    .vec_x_i (gyro_q[0]),
    .vec_y_i (gyro_q[1]),
    .vec_z_i (gyro_q[2]),
    .limit_i (gyro_lim_q),
    .still_o (gyro_still)
  );

  assign still   = accel_still && gyro_still;
  assign cnt_dec = (cnt_q != '0) ? cnt_q - COUNT_W'(1) : '0;

  // state data
  always_comb begin
    bias_d = bias_q;
    prev_d = prev_q;
    cnt_d  = cnt_q;
    case (eff_phase)
      PH_START: cnt_d = COUNT_W'({rate_q, 1'b0});
      PH_UPDATE: begin
        prev_d = accel_q;
        if (still) begin
          bias_d = bias_new;
          cnt_d  = cnt_dec;
        end
      end
      default: ;
    endcase
  end

  // next phase
  always_comb begin
    case (eff_phase)
      PH_IDLE:   phase_d = PH_IDLE;
      PH_START:  phase_d = PH_UPDATE;
      PH_UPDATE: phase_d = (cnt_d == '0) ? PH_APPLY : PH_UPDATE;
      PH_APPLY:  phase_d = PH_SAVE;
      PH_SAVE:   phase_d = PH_IDLE;
      default:   phase_d = PH_IDLE;
    endcase
  end

  // result word
  always_comb begin
    rate_out_d = gyro_q;
    done_d     = 1'b0;
    case (eff_phase)
      PH_IDLE: rate_out_d = rate_idl;
      PH_SAVE: done_d     = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      cnt_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        bias_q[i] <= '0;
        prev_q[i] <= '0;
      end
    end else if (fire) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bias_q  <= bias_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rate_out_q  <= rate_out_d;
      phase_out_q <= phase_d;
      done_q      <= done_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.rate_x           = rate_out_q[0];
  assign out_o.rate_y           = rate_out_q[1];
  assign out_o.rate_z           = rate_out_q[2];
  assign out_o.phase_now        = phase_out_q;
  assign out_o.calibration_done = done_q;

  a_bias_moves_only_when_still: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(fire && eff_phase == PH_UPDATE && still)
      |=> $stable(bias_q[0]) && $stable(bias_q[1]) && $stable(bias_q[2])
  ) else $error("bias changed outside a still update step");

  a_count_never_grows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(fire && eff_phase == PH_START) |=> cnt_q <= $past(cnt_q)
  ) else $error("countdown grew without a start step");

  a_fire_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q
  ) else $error("handled word did not reach the output register");

endmodule

### test/gyro_bias_calibration_test.sv
module gyro_bias_calibration_test;
  import gbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SW = 24;
  localparam longint SAMPLE_MAX = 64'sd8388607;
  localparam longint SAMPLE_MIN = -64'sd8388608;

  typedef struct packed {
    logic                 start_request;
    logic signed [SW-1:0] gyro_x;
    logic signed [SW-1:0] gyro_y;
    logic signed [SW-1:0] gyro_z;
    logic signed [SW-1:0] accel_x;
    logic signed [SW-1:0] accel_y;
    logic signed [SW-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic signed [SW-1:0] rate_x;
    logic signed [SW-1:0] rate_y;
    logic signed [SW-1:0] rate_z;
    logic [PHASE_W-1:0]   phase_now;
    logic                 calibration_done;
  } rate_word_t;

  logic clk = 1'b0;
  logic rst_n;

  gbc_in_if #(.SAMPLE_WIDTH(SW)) in_if ();
  gbc_out_if #(.SAMPLE_WIDTH(SW)) out_if ();
  gbc_cfg_if cfg_if ();

  gyro_bias_calibration #(.SAMPLE_WIDTH(SW)) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // calibration state as the block should hold it
  logic [RATE_W-1:0]    cal_rate;
  logic [ALPHA_W-1:0]   alpha;
  logic [LIMIT_W-1:0]   gyro_lim;
  logic [LIMIT_W-1:0]   accel_lim;
  phase_e               cal_phase;
  logic signed [SW-1:0] bias_x, bias_y, bias_z;
  logic signed [SW-1:0] prev_ax, prev_ay, prev_az;
  logic [COUNT_W-1:0]   still_left;

  rate_word_t pending_rates[$];

  int  items_sent;
  int  results_checked;
  int  mismatches;
  int  runs_finished;
  int  reg_writes;
  bit  quiet_mode;
  int  hold_request;
  int  hold_left;

  function automatic logic signed [SW-1:0] clamp_sample(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX[SW-1:0];
    if (v < SAMPLE_MIN) return SAMPLE_MIN[SW-1:0];
    return v[SW-1:0];
  endfunction

  // exact a^2 + b^2 + c^2 < lim^2, failing early on any component over the limit
  function automatic bit is_still(longint a, longint b, longint c, logic [LIMIT_W-1:0] lim);
    longint l, ua, ub, uc;
    l  = lim;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    uc = (c < 0) ? -c : c;
    if (ua > l || ub > l || uc > l) return 1'b0;
    return (ua * ua + ub * ub + uc * uc) < (l * l);
  endfunction

  function automatic logic signed [SW-1:0] step_bias(logic signed [SW-1:0] bias,
                                                     logic signed [SW-1:0] g);
    longint gl, bl, d;
    gl = g;
    bl = bias;
    d  = (gl - bl) * longint'(alpha);
    return clamp_sample(bl + (d >>> ALPHA_W));
  endfunction

  function automatic void calibrate_sample(sample_t s);
    rate_word_t r;
    bit         still_a, still_g;
    longint     gx, gy, gz, ax, ay, az;
    gx = s.gyro_x;
    gy = s.gyro_y;
    gz = s.gyro_z;
    ax = s.accel_x;
    ay = s.accel_y;
    az = s.accel_z;
    r.rate_x = s.gyro_x;
    r.rate_y = s.gyro_y;
    r.rate_z = s.gyro_z;
    r.calibration_done = 1'b0;
    if (s.start_request) cal_phase = PH_START;
    case (cal_phase)
      PH_IDLE: begin
        r.rate_x = clamp_sample(gx - longint'(bias_x));
        r.rate_y = clamp_sample(gy - longint'(bias_y));
        r.rate_z = clamp_sample(gz - longint'(bias_z));
      end
      PH_START: begin
        still_left = {cal_rate, 1'b0};
        cal_phase  = PH_UPDATE;
      end
      PH_UPDATE: begin
        still_a = is_still(ax - longint'(prev_ax), ay - longint'(prev_ay),
                           az - longint'(prev_az), accel_lim);
        still_g = is_still(gx, gy, gz, gyro_lim);
        prev_ax = s.accel_x;
        prev_ay = s.accel_y;
        prev_az = s.accel_z;
        if (still_a && still_g) begin
          bias_x = step_bias(bias_x, s.gyro_x);
          bias_y = step_bias(bias_y, s.gyro_y);
          bias_z = step_bias(bias_z, s.gyro_z);
          if (still_left != 0) still_left--;
        end
        if (still_left == 0) cal_phase = PH_APPLY;
      end
      PH_APPLY: cal_phase = PH_SAVE;
      PH_SAVE: begin
        r.calibration_done = 1'b1;
        cal_phase = PH_IDLE;
        runs_finished++;
      end
      default: cal_phase = PH_IDLE;
    endcase
    r.phase_now = cal_phase;
    pending_rates.push_back(r);
  endfunction

  function automatic sample_t sample_of(bit st, longint gx, longint gy, longint gz,
                                        longint ax, longint ay, longint az);
    sample_t s;
    s.start_request = st;
    s.gyro_x  = gx[SW-1:0];
    s.gyro_y  = gy[SW-1:0];
    s.gyro_z  = gz[SW-1:0];
    s.accel_x = ax[SW-1:0];
    s.accel_y = ay[SW-1:0];
    s.accel_z = az[SW-1:0];
    return s;
  endfunction

  function automatic longint spread(longint half);
    return longint'($urandom_range(32'(2 * half))) - half;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.start_request = ($urandom_range(7) == 0);
    s.gyro_x  = SW'($urandom);
    s.gyro_y  = SW'($urandom);
    s.gyro_z  = SW'($urandom);
    s.accel_x = SW'($urandom);
    s.accel_y = SW'($urandom);
    s.accel_z = SW'($urandom);
    return s;
  endfunction

  // small gyro and small accel change, so the word normally counts as still
  function automatic sample_t quiet_sample(bit restart);
    sample_t s;
    longint  gh, ah;
    gh = longint'(gyro_lim) / 2;
    ah = longint'(accel_lim) / 2;
    s.start_request = restart;
    s.gyro_x  = clamp_sample(spread(gh));
    s.gyro_y  = clamp_sample(spread(gh));
    s.gyro_z  = clamp_sample(spread(gh));
    s.accel_x = clamp_sample(longint'(prev_ax) + spread(ah));
    s.accel_y = clamp_sample(longint'(prev_ay) + spread(ah));
    s.accel_z = clamp_sample(longint'(prev_az) + spread(ah));
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(2))
        0:       s.gyro_y  = SW'($urandom);
        1:       s.accel_z = SW'($urandom);
        default: s.gyro_x  = SW'($urandom);
      endcase
    end
    return s;
  endfunction

  task automatic send_sample(sample_t s);
    @(negedge clk);
    if (!quiet_mode && $urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.start_request <= s.start_request;
    in_if.gyro_x        <= s.gyro_x;
    in_if.gyro_y        <= s.gyro_y;
    in_if.gyro_z        <= s.gyro_z;
    in_if.accel_x       <= s.accel_x;
    in_if.accel_y       <= s.accel_y;
    in_if.accel_z       <= s.accel_z;
    do @(posedge clk); while (!in_if.ready);
    calibrate_sample(s);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_CAL_RATE:    cal_rate  = value[RATE_W-1:0];
      REG_BIAS_ALPHA:  alpha     = value[ALPHA_W-1:0];
      REG_GYRO_LIMIT:  gyro_lim  = value[LIMIT_W-1:0];
      REG_ACCEL_LIMIT: accel_lim = value[LIMIT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // register defaults: extremes of every field, a floor on a negative bias step, restart
  task automatic test_power_up();
    send_sample(sample_of(0, 0, 0, 0, 0, 0, 0));
    send_sample(sample_of(0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                          SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
    send_sample(sample_of(0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                          SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN));
    send_sample(sample_of(0, 100, -100, 50, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN));
    send_sample(sample_of(1, 5, 5, 5, 0, 0, 0));
    drain();
  endtask

  // zero count goes straight to apply on the first update word; upper data bits ignored
  task automatic test_zero_rate();
    write_reg(REG_CAL_RATE, 23'h7FC000);
    send_sample(sample_of(1, 0, 0, 0, 0, 0, 0));
    send_sample(sample_of(0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0));
    send_sample(sample_of(0, 7, 7, 7, 0, 0, 0));
    send_sample(sample_of(0, 7, 7, 7, 0, 0, 0));
    send_sample(sample_of(0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 0, 0, 0));
    drain();
  endtask

  // near-full alpha pulls the bias to about 4843000, then idle subtraction saturates
  task automatic test_saturation();
    write_reg(REG_CAL_RATE, 23'd1);
    write_reg(REG_BIAS_ALPHA, 23'h00FFFF);
    write_reg(REG_GYRO_LIMIT, 23'h7FFFFF);
    write_reg(REG_ACCEL_LIMIT, 23'h7FFFFF);
    send_sample(sample_of(1, 0, 0, 0, 0, 0, 0));
    send_sample(sample_of(0, SAMPLE_MAX, 0, 0, 0, 0, 0));
    send_sample(sample_of(0, 4843000, -4843000, 4843000, 0, 0, 0));
    send_sample(sample_of(0, 4843000, -4843000, 4843000, 0, 0, 0));
    send_sample(sample_of(0, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 0, 0, 0));
    send_sample(sample_of(0, 0, 0, 0, 0, 0, 0));
    send_sample(sample_of(0, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 0, 0, 0));
    drain();
  endtask

  // magnitude exactly at the limit is not still, one below is
  task automatic test_still_bounds();
    write_reg(REG_BIAS_ALPHA, 23'd32768);
    write_reg(REG_GYRO_LIMIT, 23'd1000);
    write_reg(REG_ACCEL_LIMIT, 23'd100);
    send_sample(sample_of(1, 0, 0, 0, 0, 0, 0));
    send_sample(sample_of(0, 0, 0, 0, 100, 0, 0));
    send_sample(sample_of(0, 0, 0, 0, 199, 0, 0));
    send_sample(sample_of(0, 600, 800, 0, 199, 0, 0));
    send_sample(sample_of(0, 999, 0, 0, 199, 0, 0));
    send_sample(sample_of(0, 3, -3, 0, 0, 0, -1000));
    send_sample(sample_of(0, 3, -3, 0, 0, 0, 0));
    send_sample(sample_of(0, 3, -3, 0, 0, 0, 0));
    drain();
  endtask

  task automatic run_sessions(int count);
    int      stop_at, k;
    sample_t s;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        send_sample(random_sample());
      end else begin
        send_sample(quiet_sample(1'b1));
        k = 0;
        while (cal_phase != PH_IDLE && k < 60 && items_sent < stop_at) begin
          send_sample(quiet_sample(1'b0));
          k++;
        end
        repeat ($urandom_range(1, 6)) begin
          s = quiet_sample(1'b0);
          if ($urandom_range(1)) begin
            s.gyro_x = SW'($urandom);
            s.gyro_y = SW'($urandom);
            s.gyro_z = SW'($urandom);
          end
          send_sample(s);
        end
      end
    end
  endtask

  task automatic test_random_calibration();
    logic [RATE_W-1:0]  rate;
    logic [ALPHA_W-1:0] a;
    logic [LIMIT_W-1:0] g_lim, a_lim;
    logic [8:0]         junk;
    for (int p = 0; p < 10; p++) begin
      rate  = (p == 2) ? 14'h3FFF : (p == 4) ? 14'd0 : RATE_W'($urandom_range(1, 12));
      a     = (p == 1) ? 16'd0 : (p == 3) ? 16'hFFFF : ALPHA_W'($urandom);
      g_lim = (p == 5) ? 23'h7FFFFF : (p == 6) ? 23'd0 :
              (p == 7) ? LIMIT_W'($urandom_range(1, 64)) : LIMIT_W'($urandom_range(2000, 200000));
      a_lim = (p == 5) ? 23'h7FFFFF : (p == 8) ? 23'd0 :
              (p == 9) ? 23'd1 : LIMIT_W'($urandom_range(500, 100000));
      junk  = 9'($urandom);
      write_reg(REG_CAL_RATE, {junk, rate});
      write_reg(REG_BIAS_ALPHA, {junk[6:0], a});
      write_reg(REG_GYRO_LIMIT, g_lim);
      write_reg(REG_ACCEL_LIMIT, a_lim);
      // long receiver stall with the sender still offering words
      if (p == 3) hold_request = 300;
      quiet_mode = (p == 5);
      if (p == 7) begin
        run_sessions(90);
        drain();
        run_sessions(95);
      end else begin
        run_sessions(185);
      end
      drain();
    end
    quiet_mode = 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (quiet_mode) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin : check_output
    rate_word_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.rate_x           = out_if.rate_x;
      got.rate_y           = out_if.rate_y;
      got.rate_z           = out_if.rate_z;
      got.phase_now        = out_if.phase_now;
      got.calibration_done = out_if.calibration_done;
      if (pending_rates.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected word, expected none, got rate %0d %0d %0d",
                 $time, got.rate_x, got.rate_y, got.rate_z,
                 " phase %0d done %0b", got.phase_now, got.calibration_done);
      end else begin
        want = pending_rates.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          $display("%0t ns: expected rate %0d %0d %0d phase %0d done %0b,",
                   $time, want.rate_x, want.rate_y, want.rate_z, want.phase_now,
                   want.calibration_done,
                   " got rate %0d %0d %0d phase %0d done %0b",
                   got.rate_x, got.rate_y, got.rate_z,
                   got.phase_now, got.calibration_done);
        end
      end
    end
  end

  initial begin
    #6ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.start_request = 1'b0;
    in_if.gyro_x        = '0;
    in_if.gyro_y        = '0;
    in_if.gyro_z        = '0;
    in_if.accel_x       = '0;
    in_if.accel_y       = '0;
    in_if.accel_z       = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_CAL_RATE;
    cfg_if.data         = '0;
    cal_rate            = RATE_RST;
    alpha               = ALPHA_RST;
    gyro_lim            = GYRO_LIMIT_RST;
    accel_lim           = ACCEL_LIMIT_RST;
    cal_phase           = PH_START;
    bias_x              = '0;
    bias_y              = '0;
    bias_z              = '0;
    prev_ax             = '0;
    prev_ay             = '0;
    prev_az             = '0;
    still_left          = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_power_up();
    test_zero_rate();
    test_saturation();
    test_still_bounds();
    test_random_calibration();

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d samples and checked %0d output words over %0d register writes;",
             items_sent, results_checked, reg_writes);
    $display("%0d calibration runs reached save, %0d mismatching words.",
             runs_finished, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
